@@ rtl/periodic_task_scheduler_table_core_macros.svh @@
// ----------------------------------------------------------------------------
// Periodic task scheduler table - assertion macros
// Shared property templates for the port-level checker. Each expects clk and
// rst_n in the scope of the use.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_TABLE_CORE_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define PTST_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define PTST_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/ptst_pkg.sv @@
// ----------------------------------------------------------------------------
// ptst_pkg
// Types and constants shared by the periodic task scheduler table modules.
// ----------------------------------------------------------------------------
package ptst_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int RESULT_CAP    = 8;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_ADD      = 2'd1,
        KIND_DISPATCH = 2'd2,
        KIND_CLEAR    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  task_id;
        logic [31:0] start_delay;
        logic [31:0] period_ticks;
    } cmd_t;

    typedef struct packed {
        logic [2:0] slot_index;
        logic [7:0] due_task;
        logic       table_full;
        logic       due_valid;
        logic       last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_ADD,
        ST_DSCAN,
        ST_DHOLD,
        ST_DFLUSH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;       // latch item, rewind slot counter
        logic clear_all;
        logic cnt_inc;
        logic tick_run;
        logic add_write;
        logic push_full;
        logic disp_take;   // take current ready slot, push previous one
        logic disp_flush;  // push final dispatch result
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cnt_end;
        logic slot_occ;
        logic slot_ready;
        logic cap_hit;
        logic pend_vld;
        logic can_load;
    } ctrl_sts_t;

endpackage

@@ rtl/ptst_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptst_ctrl
// Sequencer for the scheduler table: walks the slot counter for tick, add
// and dispatch and issues commands to the datapath.
// ----------------------------------------------------------------------------
module ptst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  ptst_pkg::kind_t       cmd_kind,
    input  ptst_pkg::ctrl_sts_t   sts,
    output logic                  busy,
    output ptst_pkg::ctrl_cmd_t   cc
);
    import ptst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_kind)
                        KIND_TICK:     state_next = ST_TICK;
                        KIND_ADD:      state_next = ST_ADD;
                        KIND_DISPATCH: state_next = ST_DSCAN;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK:
            begin
                if (sts.cnt_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                if ((sts.cnt_end || !sts.slot_occ) && sts.can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DSCAN:
            begin
                if (sts.cnt_end || sts.cap_hit)
                begin
                    state_next = ST_DFLUSH;
                end
                else if (sts.slot_ready)
                begin
                    state_next = ST_DHOLD;
                end
            end
            ST_DHOLD:
            begin
                if (!sts.pend_vld || sts.can_load)
                begin
                    state_next = ST_DSCAN;
                end
            end
            ST_DFLUSH:
            begin
                if (sts.can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cc   = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (cmd_valid)
                begin
                    cc.start     = 1'b1;
                    cc.clear_all = (cmd_kind == KIND_CLEAR);
                end
            end
            ST_TICK:
            begin
                cc.tick_run = 1'b1;
                cc.cnt_inc  = !sts.cnt_end;
            end
            ST_ADD:
            begin
                if (sts.cnt_end)
                begin
                    cc.push_full = sts.can_load;
                end
                else if (sts.slot_occ)
                begin
                    cc.cnt_inc = 1'b1;
                end
                else
                begin
                    cc.add_write = sts.can_load;
                end
            end
            ST_DSCAN:
            begin
                cc.cnt_inc = !sts.cnt_end && !sts.cap_hit && !sts.slot_ready;
            end
            ST_DHOLD:
            begin
                if (!sts.pend_vld || sts.can_load)
                begin
                    cc.disp_take = 1'b1;
                    cc.cnt_inc   = 1'b1;
                end
            end
            ST_DFLUSH:
            begin
                cc.disp_flush = sts.can_load;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ rtl/ptst_datapath.sv @@
// ----------------------------------------------------------------------------
// ptst_datapath
// Slot storage (handle, countdown and period memories, occupied and ready
// flags), slot counter, tick writeback stage, dispatch holding register and
// the result output register.
// ----------------------------------------------------------------------------
module ptst_datapath #(
    parameter int NUM_SLOTS = ptst_pkg::NUM_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptst_pkg::cmd_t        cmd,
    input  ptst_pkg::ctrl_cmd_t   cc,
    output ptst_pkg::ctrl_sts_t   sts,
    output logic                  res_valid,
    input  logic                  res_stall,
    output ptst_pkg::res_t        res
);
    import ptst_pkg::*;

    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int TAKE_W    = $clog2(RESULT_CAP + 1);
    localparam int IDX_EXT_W = (SLOT_W > 3) ? SLOT_W : 3;

    cmd_t                item_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [SLOT_W-1:0]   idx;
    logic                cnt_end;

    logic [NUM_SLOTS-1:0] occ_reg;
    logic [NUM_SLOTS-1:0] occ_next;
    logic [NUM_SLOTS-1:0] ready_reg;
    logic [NUM_SLOTS-1:0] ready_next;

    logic [7:0]  hnd_mem [NUM_SLOTS];
    logic [31:0] cd_mem  [NUM_SLOTS];
    logic [31:0] per_mem [NUM_SLOTS];
    logic [7:0]  hnd_rd_reg;
    logic [31:0] cd_rd_reg;
    logic [31:0] per_rd_reg;

    logic              wb_vld_reg;
    logic [SLOT_W-1:0] wb_idx_reg;
    logic              tick_wb;
    logic              cd_zero;
    logic              cd_we;
    logic [SLOT_W-1:0] cd_wa;
    logic [31:0]       cd_wd;

    logic              pend_vld_reg;
    logic              pend_vld_next;
    logic [SLOT_W-1:0] pend_idx_reg;
    logic [7:0]        pend_task_reg;
    logic [TAKE_W-1:0] take_reg;
    logic [TAKE_W-1:0] take_next;

    logic [IDX_EXT_W-1:0] idx_ext;
    logic [IDX_EXT_W-1:0] pend_ext;

    res_t res_reg;
    res_t res_d;
    logic res_load;
    logic res_vld_reg;
    logic res_vld_next;
    logic can_load;

    assign idx      = cnt_reg[SLOT_W-1:0];
    assign cnt_end  = (cnt_reg == CNT_W'(NUM_SLOTS));
    assign idx_ext  = IDX_EXT_W'(idx);
    assign pend_ext = IDX_EXT_W'(pend_idx_reg);
    assign can_load = !res_vld_reg || !res_stall;

    assign sts.cnt_end    = cnt_end;
    assign sts.slot_occ   = !cnt_end && occ_reg[idx];
    assign sts.slot_ready = !cnt_end && ready_reg[idx];
    assign sts.cap_hit    = (take_reg == TAKE_W'(RESULT_CAP));
    assign sts.pend_vld   = pend_vld_reg;
    assign sts.can_load   = can_load;

    // tick writeback: slot read last cycle is updated this cycle
    assign tick_wb = wb_vld_reg && occ_reg[wb_idx_reg];
    assign cd_zero = (cd_rd_reg == 32'd0);
    assign cd_we   = cc.add_write || tick_wb;
    assign cd_wa   = cc.add_write ? idx : wb_idx_reg;

    always_comb
    begin
        if (cc.add_write)
        begin
            cd_wd = item_reg.start_delay;
        end
        else if (cd_zero)
        begin
            cd_wd = per_rd_reg - 32'd1;
        end
        else
        begin
            cd_wd = cd_rd_reg - 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cc.add_write)
        begin
            hnd_mem[idx] <= item_reg.task_id;
            per_mem[idx] <= item_reg.period_ticks;
        end
        if (cd_we)
        begin
            cd_mem[cd_wa] <= cd_wd;
        end
        if (!cnt_end)
        begin
            hnd_rd_reg <= hnd_mem[idx];
            cd_rd_reg  <= cd_mem[idx];
            per_rd_reg <= per_mem[idx];
        end
    end

    always_comb
    begin
        occ_next   = occ_reg;
        ready_next = ready_reg;
        if (cc.clear_all)
        begin
            occ_next   = '0;
            ready_next = '0;
        end
        if (tick_wb && cd_zero)
        begin
            ready_next[wb_idx_reg] = 1'b1;
        end
        if (cc.add_write)
        begin
            occ_next[idx]   = (item_reg.task_id != 8'd0);
            ready_next[idx] = 1'b0;
        end
        if (cc.disp_take)
        begin
            ready_next[idx] = 1'b0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cc.start)
        begin
            cnt_next = '0;
        end
        else if (cc.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        take_next     = take_reg;
        if (cc.start)
        begin
            pend_vld_next = 1'b0;
            take_next     = '0;
        end
        else if (cc.disp_take)
        begin
            pend_vld_next = 1'b1;
            take_next     = take_reg + TAKE_W'(1);
        end
    end

    always_comb
    begin
        res_d    = '0;
        res_load = 1'b0;
        if (cc.add_write)
        begin
            res_d.slot_index = idx_ext[2:0];
            res_d.last       = 1'b1;
            res_load         = 1'b1;
        end
        else if (cc.push_full)
        begin
            res_d.table_full = 1'b1;
            res_d.last       = 1'b1;
            res_load         = 1'b1;
        end
        else if (cc.disp_take && pend_vld_reg)
        begin
            res_d.slot_index = pend_ext[2:0];
            res_d.due_task   = pend_task_reg;
            res_d.due_valid  = 1'b1;
            res_load         = 1'b1;
        end
        else if (cc.disp_flush)
        begin
            if (pend_vld_reg)
            begin
                res_d.slot_index = pend_ext[2:0];
                res_d.due_task   = pend_task_reg;
                res_d.due_valid  = 1'b1;
            end
            res_d.last = 1'b1;
            res_load   = 1'b1;
        end
    end

    assign res_vld_next = res_load ? 1'b1 : (res_vld_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            occ_reg      <= '0;
            ready_reg    <= '0;
            wb_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            take_reg     <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            occ_reg      <= occ_next;
            ready_reg    <= ready_next;
            wb_vld_reg   <= cc.tick_run && !cnt_end;
            pend_vld_reg <= pend_vld_next;
            take_reg     <= take_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_idx_reg <= idx;
        if (cc.start)
        begin
            item_reg <= cmd;
        end
        if (cc.disp_take)
        begin
            pend_idx_reg  <= idx;
            pend_task_reg <= hnd_rd_reg;
        end
        if (res_load)
        begin
            res_reg <= res_d;
        end
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

endmodule

@@ rtl/periodic_task_scheduler_table_core.sv @@
// ----------------------------------------------------------------------------
// periodic_task_scheduler_table_core
// Table of periodic task slots with tick, add, dispatch and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one command at a time;
//   cmd_stall is high while a command is being worked on.
//   res channel (res_valid / res_stall / res) returns results from a single
//   output register; each command's final result has last set.
//   Command sequences:
//     clear    - done in the idle state, no result.
//     tick     - one slot per cycle through a read/writeback pair (reads
//                countdown and period, writes back countdown); no result.
//     add      - scans slots one per cycle; result registered once the
//                first free slot is written, or a full report when full.
//     dispatch - steps past idle slots, holds each ready slot until taken,
//                then end check and final result; at most eight results.
//   The next command is taken in the idle state after a command completes.
//   A held res_stall freezes the result; the controller waits on it to load the next one.
//   Reset empties every slot and clears all ready marks immediately.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_table_core #(
    parameter int NUM_SLOTS = ptst_pkg::NUM_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  ptst_pkg::cmd_t   cmd,
    output logic             res_valid,
    input  logic             res_stall,
    output ptst_pkg::res_t   res
);
    import ptst_pkg::*;

    ctrl_cmd_t cc;
    ctrl_sts_t sts;

    ptst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_kind  (cmd.kind),
        .sts       (sts),
        .busy      (cmd_stall),
        .cc        (cc)
    );

    ptst_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cc        (cc),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

@@ rtl/ptst_checker.sv @@
// ----------------------------------------------------------------------------
// ptst_checker
// Port-level checks for the scheduler table, bound to the top level.
// ----------------------------------------------------------------------------
`include "periodic_task_scheduler_table_core_macros.svh"

module ptst_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic             cmd_stall,
    input  ptst_pkg::cmd_t   cmd,
    input  logic             res_valid,
    input  logic             res_stall,
    input  ptst_pkg::res_t   res
);
    import ptst_pkg::*;

    // a dispatched task is never an empty slot and never a full report
    `PTST_ASSERT_SAME(a_due_named, res_valid && res.due_valid, res.due_task != 8'd0 && !res.table_full, "due result without task")

    // a full report stands alone with zero slot
    `PTST_ASSERT_SAME(a_full_form, res_valid && res.table_full, res.last && !res.due_valid && res.slot_index == 3'd0, "malformed full result")

    // results that name no task always end their command
    `PTST_ASSERT_SAME(a_empty_last, res_valid && !res.due_valid, res.last && res.due_task == 8'd0, "empty result not last")

    // clear leaves the block free for a command in the next cycle
    `PTST_ASSERT_NEXT(a_clear_quick, cmd_valid && !cmd_stall && cmd.kind == KIND_CLEAR, !cmd_stall, "clear held the block")

    `PTST_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

endmodule

bind periodic_task_scheduler_table_core ptst_checker u_ptst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
